// File: rtl/assert_macros.svh
// Assertion macros used by the block's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rmbs_pkg.sv
// Shared widths, types and register codes of the background subtraction block.
`default_nettype none

package rmbs_pkg;

  localparam int PIX_W     = 20;
  localparam int CH_W      = 8;
  localparam int WGT_W     = 8;
  localparam int SHF_W     = 4;
  localparam int SUM_W     = 16;
  localparam int PROD_W    = CH_W + WGT_W;
  localparam int VAL_W     = PROD_W + 2;
  localparam int DIFF_W    = 16;
  localparam int NCH       = 3;
  localparam int LIM_W     = 25;
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 3;

  // Channel 0 is red, 1 green, 2 blue.
  typedef logic [NCH-1:0][SUM_W-1:0]  sums_t;
  typedef logic [NCH-1:0][CH_W-1:0]   rgb_t;
  typedef logic [NCH-1:0][VAL_W-1:0]  vals_t;
  typedef logic [NCH-1:0][DIFF_W-1:0] diffs_t;

  typedef struct packed {
    logic             en;
    logic [PIX_W-1:0] idx;
    sums_t            data;
  } sum_wr_t;

  typedef struct packed {
    logic ld1;
    logic ld2;
    logic leave2;
  } front_ctl_t;

  typedef struct packed {
    logic ld_a;
    logic ld_b;
    logic ld_c;
  } lane_ctl_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GREY_MODE    = 3'd0,
    REG_WEIGHT_RED   = 3'd1,
    REG_WEIGHT_GREEN = 3'd2,
    REG_WEIGHT_BLUE  = 3'd3,
    REG_WEIGHT_SHIFT = 3'd4
  } reg_idx_t;

endpackage

`default_nettype wire

// File: rtl/rmbs_sum_store.sv
// Running-sum memory with one read and one write port and a clearing sweep after reset.
`default_nettype none

module rmbs_sum_store #(
  parameter int DEPTH  = 1048576,
  parameter int ADDR_W = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output rmbs_pkg::sums_t   rd_data,
  input  rmbs_pkg::sum_wr_t wr,
  output logic              clearing
);
  import rmbs_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  sums_t             mem [DEPTH];
  sums_t             rd_data_r;
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == LAST_ADDR) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr.en) begin
      mem[wr.idx[ADDR_W-1:0]] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_busy_r;

endmodule

`default_nettype wire

// File: rtl/rmbs_front.sv
// Front stages: weighting, sum fetch with write-back bypass, grey value and sum update.
`default_nettype none

module rmbs_front #(
  parameter int MAX_PIXELS = 1048576
) (
  input  logic                               clk,
  input  rmbs_pkg::front_ctl_t               ctl,
  input  logic                               grey_mode,
  input  rmbs_pkg::rgb_t                     weight,
  input  logic [rmbs_pkg::SHF_W-1:0]         weight_shift,
  input  logic [rmbs_pkg::PIX_W-1:0]         in_pixel_index,
  input  rmbs_pkg::rgb_t                     in_new,
  input  rmbs_pkg::rgb_t                     in_old,
  input  rmbs_pkg::sums_t                    mem_q,
  output rmbs_pkg::sum_wr_t                  wr,
  output rmbs_pkg::vals_t                    lane_p,
  output rmbs_pkg::sums_t                    lane_s
);
  import rmbs_pkg::*;

  localparam logic [LIM_W-1:0] PIX_LIMIT = LIM_W'(MAX_PIXELS);

  // stage 1
  logic [PIX_W-1:0] s1_idx_r;
  logic             s1_in_range_r;
  rgb_t             s1_new_r;
  rgb_t             s1_old_r;
  logic             s1_fwd_r;
  sums_t            s1_fwd_data_r;
  // stage 2
  logic [PIX_W-1:0]              s2_idx_r;
  logic                          s2_in_range_r;
  rgb_t                          s2_new_r;
  rgb_t                          s2_old_r;
  logic [NCH-1:0][PROD_W-1:0]    s2_new_prod_r;
  logic [NCH-1:0][PROD_W-1:0]    s2_old_prod_r;
  sums_t                         s2_sum_r;

  logic [NCH-1:0][PROD_W-1:0] new_prod;
  logic [NCH-1:0][PROD_W-1:0] old_prod;
  sums_t                      s1_sum;
  logic [VAL_W-1:0]           grey_new;
  logic [VAL_W-1:0]           grey_old;
  sums_t                      sum_nxt;

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      new_prod[k] = PROD_W'(s1_new_r[k]) * PROD_W'(weight[k]);
      old_prod[k] = PROD_W'(s1_old_r[k]) * PROD_W'(weight[k]);
    end
    // out-of-range pixels read as an empty window
    if (!s1_in_range_r) begin
      s1_sum = '0;
    end else if (s1_fwd_r) begin
      s1_sum = s1_fwd_data_r;
    end else begin
      s1_sum = mem_q;
    end
  end

  always_comb begin
    grey_new = (VAL_W'(s2_new_prod_r[0]) + VAL_W'(s2_new_prod_r[1])
                + VAL_W'(s2_new_prod_r[2])) >> weight_shift;
    grey_old = (VAL_W'(s2_old_prod_r[0]) + VAL_W'(s2_old_prod_r[1])
                + VAL_W'(s2_old_prod_r[2])) >> weight_shift;
    sum_nxt = s2_sum_r;
    lane_p  = '0;
    if (grey_mode) begin
      // grey mode keeps its sum in the red slot
      sum_nxt[0] = s2_sum_r[0] + grey_new[SUM_W-1:0] - grey_old[SUM_W-1:0];
      lane_p[0]  = grey_new;
      lane_p[1]  = VAL_W'(s2_new_r[1]);
      lane_p[2]  = VAL_W'(s2_new_r[2]);
    end else begin
      for (int k = 0; k < NCH; k++) begin
        sum_nxt[k] = s2_sum_r[k] + SUM_W'(s2_new_r[k]) - SUM_W'(s2_old_r[k]);
        lane_p[k]  = VAL_W'(s2_new_r[k]);
      end
    end
  end

  assign lane_s  = s2_sum_r;
  assign wr.en   = ctl.leave2 && s2_in_range_r;
  assign wr.idx  = s2_idx_r;
  assign wr.data = sum_nxt;

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      s1_idx_r      <= in_pixel_index;
      s1_in_range_r <= LIM_W'(in_pixel_index) < PIX_LIMIT;
      s1_new_r      <= in_new;
      s1_old_r      <= in_old;
      // memory read at this edge misses a write landing at the same edge
      s1_fwd_r      <= wr.en && (in_pixel_index == s2_idx_r);
      s1_fwd_data_r <= sum_nxt;
    end
    if (ctl.ld2) begin
      s2_idx_r      <= s1_idx_r;
      s2_in_range_r <= s1_in_range_r;
      s2_new_r      <= s1_new_r;
      s2_old_r      <= s1_old_r;
      s2_new_prod_r <= new_prod;
      s2_old_prod_r <= old_prod;
      // take the sum the item ahead writes back as this one moves up
      s2_sum_r      <= (wr.en && (s1_idx_r == s2_idx_r)) ? sum_nxt : s1_sum;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rmbs_lane_div.sv
// One lane of (N*p - s)/N, truncated toward zero, as three register stages.
`default_nettype none

module rmbs_lane_div #(
  parameter int WINDOW_FRAMES = 16
) (
  input  logic                          clk,
  input  rmbs_pkg::lane_ctl_t           ctl,
  input  logic [rmbs_pkg::VAL_W-1:0]    p,
  input  logic [rmbs_pkg::SUM_W-1:0]    s,
  output logic [rmbs_pkg::DIFF_W-1:0]   d
);
  import rmbs_pkg::*;

  localparam int N_W    = $clog2(WINDOW_FRAMES + 1);
  localparam int NP_W   = VAL_W + N_W;
  localparam int RCP_SH = SUM_W;
  localparam int RCP_W  = SUM_W + 1;
  localparam int MR_W   = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP     = RCP_W'((1 << RCP_SH) / WINDOW_FRAMES);
  localparam logic [NP_W-1:0]  N_WIDE  = NP_W'(WINDOW_FRAMES);
  localparam logic [SUM_W-1:0] N_NARROW = SUM_W'(WINDOW_FRAMES);

  // stage A: magnitude of -s and reciprocal estimate of |s|/N
  logic              s_neg;
  logic [SUM_W-1:0]  mag;
  logic [MR_W-1:0]   mag_rcp;
  logic              x_nonneg;
  logic              t_neg;
  logic [DIFF_W-1:0] a_p_r;
  logic [SUM_W-1:0]  a_mag_r;
  logic [SUM_W-1:0]  a_q_r;
  logic              a_tneg_r;
  logic              a_xnn_r;

  // stage B: one correction step
  logic [SUM_W-1:0]  q_times_n;
  logic [SUM_W-1:0]  rem;
  logic              rem_over;
  logic [SUM_W-1:0]  q_nxt;
  logic [SUM_W-1:0]  rem_nxt;
  logic [DIFF_W-1:0] b_p_r;
  logic [SUM_W-1:0]  b_q_r;
  logic              b_rnz_r;
  logic              b_tneg_r;
  logic              b_xnn_r;

  // stage C: round toward zero and add to the pixel
  logic [SUM_W-1:0]  mag_adj;
  logic [DIFF_W-1:0] d_nxt;
  logic [DIFF_W-1:0] c_d_r;

  always_comb begin
    s_neg    = s[SUM_W-1];
    mag      = s_neg ? SUM_W'(~s + 1'b1) : s;
    t_neg    = !s_neg && (s != '0);
    x_nonneg = s_neg || ((NP_W'(p) * N_WIDE) >= NP_W'(s));
    mag_rcp  = MR_W'(mag) * MR_W'(RCP);
  end

  always_comb begin
    q_times_n = a_q_r * N_NARROW;
    rem       = a_mag_r - q_times_n;
    rem_over  = rem >= N_NARROW;
    q_nxt     = rem_over ? a_q_r + 1'b1 : a_q_r;
    rem_nxt   = rem_over ? rem - N_NARROW : rem;
  end

  always_comb begin
    // a nonzero remainder rounds up the magnitude when floor and sign disagree
    mag_adj = b_q_r + SUM_W'(b_rnz_r && (b_xnn_r == b_tneg_r));
    d_nxt   = b_tneg_r ? b_p_r - mag_adj : b_p_r + mag_adj;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_a) begin
      a_p_r    <= p[DIFF_W-1:0];
      a_mag_r  <= mag;
      a_q_r    <= mag_rcp[RCP_SH +: SUM_W];
      a_tneg_r <= t_neg;
      a_xnn_r  <= x_nonneg;
    end
    if (ctl.ld_b) begin
      b_p_r    <= a_p_r;
      b_q_r    <= q_nxt;
      b_rnz_r  <= rem_nxt != '0;
      b_tneg_r <= a_tneg_r;
      b_xnn_r  <= a_xnn_r;
    end
    if (ctl.ld_c) begin
      c_d_r <= d_nxt;
    end
  end

  assign d = c_d_r;

endmodule

`default_nettype wire

// File: rtl/running_mean_background_subtract.sv
// Top level: register port, pipeline control, output stage and running-sum memory.
`default_nettype none
`include "assert_macros.svh"

// Running-mean background subtraction. Each request carries a pixel index, the
// pixel's new RGB value and the RGB value leaving the N-frame window; the result
// is the pixel minus the window mean (grey or per-channel weighted). The block
// takes one request per clock unless in_stall is high (clearing pass or output
// back-pressure); that rate is set by the sum memory, which does one read and one
// write each cycle, with back-to-back requests on the same pixel resolved by a
// write-back bypass. After reset a clearing pass zeroes the sum memory, one entry
// a cycle, over all min(MAX_PIXELS, 2^20) entries; in_stall stays high until it
// ends, while register writes are taken throughout. Write registers only while no
// requests are in flight.
module running_mean_background_subtract #(
  parameter int WINDOW_FRAMES = 16,
  parameter int MAX_PIXELS    = 1048576
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rmbs_pkg::APB_AW-1:0]         paddr,
  input  logic [rmbs_pkg::APB_DW-1:0]         pwdata,
  output logic [rmbs_pkg::APB_DW-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rmbs_pkg::PIX_W-1:0]          in_pixel_index,
  input  logic [rmbs_pkg::CH_W-1:0]           in_new_red,
  input  logic [rmbs_pkg::CH_W-1:0]           in_new_green,
  input  logic [rmbs_pkg::CH_W-1:0]           in_new_blue,
  input  logic [rmbs_pkg::CH_W-1:0]           in_old_red,
  input  logic [rmbs_pkg::CH_W-1:0]           in_old_green,
  input  logic [rmbs_pkg::CH_W-1:0]           in_old_blue,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rmbs_pkg::DIFF_W-1:0]  out_difference
);
  import rmbs_pkg::*;

  localparam int MEM_DEPTH = (MAX_PIXELS < (1 << PIX_W)) ? MAX_PIXELS : (1 << PIX_W);
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int NSTG      = 6;
  localparam logic [LIM_W-1:0] PIX_LIMIT = LIM_W'(MAX_PIXELS);

  logic                     grey_mode_r;
  rgb_t                     weight_r;
  logic [SHF_W-1:0]         weight_shift_r;
  reg_idx_t                 reg_sel;

  logic [NSTG-1:0]          v_r;
  logic [NSTG-1:0]          ld;
  logic                     accept;
  logic                     clearing;

  rgb_t                     in_new;
  rgb_t                     in_old;
  sums_t                    mem_q;
  sum_wr_t                  sum_wr;
  front_ctl_t               front_ctl;
  lane_ctl_t                lane_ctl;
  vals_t                    lane_p;
  sums_t                    lane_s;
  diffs_t                   lane_d;

  logic [DIFF_W-1:0]        out_nxt;
  logic signed [DIFF_W-1:0] out_difference_r;

  // register port
  assign reg_sel = reg_idx_t'(paddr[APB_AW-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grey_mode_r    <= 1'b1;
      weight_r       <= {NCH{WGT_W'(1)}};
      weight_shift_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_GREY_MODE:    grey_mode_r    <= pwdata[0];
        REG_WEIGHT_RED:   weight_r[0]    <= pwdata[WGT_W-1:0];
        REG_WEIGHT_GREEN: weight_r[1]    <= pwdata[WGT_W-1:0];
        REG_WEIGHT_BLUE:  weight_r[2]    <= pwdata[WGT_W-1:0];
        REG_WEIGHT_SHIFT: weight_shift_r <= pwdata[SHF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_GREY_MODE:    prdata = APB_DW'(grey_mode_r);
      REG_WEIGHT_RED:   prdata = APB_DW'(weight_r[0]);
      REG_WEIGHT_GREEN: prdata = APB_DW'(weight_r[1]);
      REG_WEIGHT_BLUE:  prdata = APB_DW'(weight_r[2]);
      REG_WEIGHT_SHIFT: prdata = APB_DW'(weight_shift_r);
      default:          prdata = '0;
    endcase
  end

  // pipeline control: a stage loads when empty or when the stage after it loads
  always_comb begin
    ld[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign in_stall = clearing || !ld[0];
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= accept;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (ld[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign front_ctl.ld1    = ld[0];
  assign front_ctl.ld2    = ld[1];
  assign front_ctl.leave2 = v_r[1] && ld[2];
  assign lane_ctl.ld_a    = ld[2];
  assign lane_ctl.ld_b    = ld[3];
  assign lane_ctl.ld_c    = ld[4];

  assign in_new = {in_new_blue, in_new_green, in_new_red};
  assign in_old = {in_old_blue, in_old_green, in_old_red};

  rmbs_sum_store #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (ld[0]),
    .rd_addr  (in_pixel_index[ADDR_W-1:0]),
    .rd_data  (mem_q),
    .wr       (sum_wr),
    .clearing (clearing)
  );

  rmbs_front #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_front (
    .clk            (clk),
    .ctl            (front_ctl),
    .grey_mode      (grey_mode_r),
    .weight         (weight_r),
    .weight_shift   (weight_shift_r),
    .in_pixel_index (in_pixel_index),
    .in_new         (in_new),
    .in_old         (in_old),
    .mem_q          (mem_q),
    .wr             (sum_wr),
    .lane_p         (lane_p),
    .lane_s         (lane_s)
  );

  for (genvar k = 0; k < NCH; k++) begin : g_lane
    rmbs_lane_div #(
      .WINDOW_FRAMES (WINDOW_FRAMES)
    ) u_lane (
      .clk (clk),
      .ctl (lane_ctl),
      .p   (lane_p[k]),
      .s   (lane_s[k]),
      .d   (lane_d[k])
    );
  end

  // output stage: scale the grey difference back up, or weight the channels
  always_comb begin
    if (grey_mode_r) begin
      out_nxt = DIFF_W'(lane_d[0] << weight_shift_r);
    end else begin
      out_nxt = DIFF_W'(lane_d[0] * DIFF_W'(weight_r[0]))
              + DIFF_W'(lane_d[1] * DIFF_W'(weight_r[1]))
              + DIFF_W'(lane_d[2] * DIFF_W'(weight_r[2]));
    end
  end

  always_ff @(posedge clk) begin
    if (ld[NSTG-1]) begin
      out_difference_r <= $signed(out_nxt);
    end
  end

  assign out_valid      = v_r[NSTG-1];
  assign out_difference = out_difference_r;

  `ASSERT_IMPLY(a_clear_pipe_empty, clk, rst_n, clearing, v_r == '0, "request in flight during clearing pass")
  `ASSERT_IMPLY(a_wr_in_range, clk, rst_n, sum_wr.en, LIM_W'(sum_wr.idx) < PIX_LIMIT, "sum write to out-of-range pixel")
  `ASSERT_NEXT(a_clear_no_restart, clk, rst_n, !clearing, !clearing, "clearing pass restarted without reset")

endmodule

`default_nettype wire

// File: tb/tb_running_mean_background_subtract.sv
// Self-checking testbench for the running-mean background subtraction block.
`default_nettype none

module tb_running_mean_background_subtract;
  timeunit 1ns;
  timeprecision 1ps;

  import rmbs_pkg::*;

  localparam int WINDOW_N     = 16;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int HIST_SLOTS   = 16;

  typedef enum int {
    IDLE_SENDER_LIGHT,
    IDLE_SENDER_HEAVY,
    IDLE_NONE
  } idle_mode_t;

  typedef struct packed {
    logic [PIX_W-1:0] idx;
    rgb_t             new_px;
    rgb_t             old_px;
  } pixel_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [PIX_W-1:0]  in_pixel_index = '0;
  logic [CH_W-1:0]   in_new_red = '0;
  logic [CH_W-1:0]   in_new_green = '0;
  logic [CH_W-1:0]   in_new_blue = '0;
  logic [CH_W-1:0]   in_old_red = '0;
  logic [CH_W-1:0]   in_old_green = '0;
  logic [CH_W-1:0]   in_old_blue = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [DIFF_W-1:0] out_difference;

  running_mean_background_subtract #(
    .WINDOW_FRAMES(WINDOW_N),
    .MAX_PIXELS   (1048576)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel_index(in_pixel_index),
    .in_new_red    (in_new_red),
    .in_new_green  (in_new_green),
    .in_new_blue   (in_new_blue),
    .in_old_red    (in_old_red),
    .in_old_green  (in_old_green),
    .in_old_blue   (in_old_blue),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_difference(out_difference)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor copy of the registers and the per-pixel sums.
  logic             cfg_grey_mode = 1'b1;
  logic [WGT_W-1:0] cfg_weight_red = 8'd1;
  logic [WGT_W-1:0] cfg_weight_green = 8'd1;
  logic [WGT_W-1:0] cfg_weight_blue = 8'd1;
  logic [SHF_W-1:0] cfg_weight_shift = 4'd0;
  sums_t            window_sum_mem [logic [PIX_W-1:0]];

  pixel_req_t        pixel_req_q [$];
  logic [DIFF_W-1:0] diff_expect_q [$];
  rgb_t              frame_history [HIST_SLOTS][$];
  pixel_req_t        cur_req;
  logic [DIFF_W-1:0] want_diff;

  int issued_count = 0;
  int checked_count = 0;
  int fail_count = 0;
  int send_idle_pct = 15;
  int recv_idle_pct = 49;
  int last_slot = 0;
  logic hold_go = 1'b0;
  logic out_hold = 1'b0;

  function automatic logic [DIFF_W-1:0] predict_difference(input pixel_req_t r);
    sums_t             s;
    int                w [NCH];
    int                v_new;
    int                v_old;
    int                q;
    int                acc;
    int                k;
    logic [DIFF_W-1:0] res;
    s = window_sum_mem.exists(r.idx) ? window_sum_mem[r.idx] : '0;
    w[0] = int'(cfg_weight_red);
    w[1] = int'(cfg_weight_green);
    w[2] = int'(cfg_weight_blue);
    if (cfg_grey_mode) begin
      v_new = (int'(r.new_px[0]) * w[0] + int'(r.new_px[1]) * w[1] +
               int'(r.new_px[2]) * w[2]) >> cfg_weight_shift;
      v_old = (int'(r.old_px[0]) * w[0] + int'(r.old_px[1]) * w[1] +
               int'(r.old_px[2]) * w[2]) >> cfg_weight_shift;
      // grey value shares the red sum slot
      q = (WINDOW_N * v_new - int'($signed(s[0]))) / WINDOW_N;
      res = DIFF_W'(q << cfg_weight_shift);
      s[0] = SUM_W'(int'(s[0]) + v_new - v_old);
    end else begin
      acc = 0;
      for (k = 0; k < NCH; k++) begin
        acc += ((WINDOW_N * int'(r.new_px[k]) - int'($signed(s[k]))) / WINDOW_N) * w[k];
        s[k] = SUM_W'(int'(s[k]) + int'(r.new_px[k]) - int'(r.old_px[k]));
      end
      res = DIFF_W'(acc);
    end
    window_sum_mem[r.idx] = s;
    return res;
  endfunction

  // Request driver: present the next pending request once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        diff_expect_q.insert(diff_expect_q.size(), predict_difference(cur_req));
      end
      if (!in_valid || !in_stall) begin
        if (pixel_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pixel_req_q.pop_front();
          in_pixel_index <= cur_req.idx;
          in_new_red     <= cur_req.new_px[0];
          in_new_green   <= cur_req.new_px[1];
          in_new_blue    <= cur_req.new_px[2];
          in_old_red     <= cur_req.old_px[0];
          in_old_green   <= cur_req.old_px[1];
          in_old_blue    <= cur_req.old_px[2];
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (diff_expect_q.size() == 0) begin
          $error("difference: no result expected, got %0d", out_difference);
          fail_count++;
        end else begin
          want_diff = diff_expect_q.pop_front();
          if (out_difference !== want_diff) begin
            $error("difference: expected %0d, got %0d", $signed(want_diff), out_difference);
            fail_count++;
          end
          checked_count <= checked_count + 1;
        end
      end
      out_stall <= out_hold || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Long receiver hold-off so the pipeline backs up into the input.
  initial begin
    while (!hold_go) @(posedge clk);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    out_hold <= 1'b0;
  end

  initial begin
    #100ms;
    $display("running_mean_background_subtract regression: fail");
    $finish;
  end

  task automatic reg_write(input reg_idx_t idx, input logic [APB_DW-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GREY_MODE:    cfg_grey_mode = val[0];
      REG_WEIGHT_RED:   cfg_weight_red = val[WGT_W-1:0];
      REG_WEIGHT_GREEN: cfg_weight_green = val[WGT_W-1:0];
      REG_WEIGHT_BLUE:  cfg_weight_blue = val[WGT_W-1:0];
      REG_WEIGHT_SHIFT: cfg_weight_shift = val[SHF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (checked_count != issued_count) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic grey, input logic [WGT_W-1:0] wr,
                           input logic [WGT_W-1:0] wg, input logic [WGT_W-1:0] wb,
                           input logic [SHF_W-1:0] sh, input idle_mode_t mode);
    drain();
    reg_write(REG_GREY_MODE, APB_DW'(grey));
    reg_write(REG_WEIGHT_RED, APB_DW'(wr));
    reg_write(REG_WEIGHT_GREEN, APB_DW'(wg));
    reg_write(REG_WEIGHT_BLUE, APB_DW'(wb));
    reg_write(REG_WEIGHT_SHIFT, APB_DW'(sh));
    case (mode)
      IDLE_SENDER_LIGHT: begin
        send_idle_pct <= 15;
        recv_idle_pct <= 49;
      end
      IDLE_SENDER_HEAVY: begin
        send_idle_pct <= 49;
        recv_idle_pct <= 15;
      end
      default: begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
    endcase
  endtask

  function automatic void push_req(input logic [PIX_W-1:0] idx, input rgb_t new_px,
                                   input rgb_t old_px);
    pixel_req_q.insert(pixel_req_q.size(),
                       pixel_req_t'{idx: idx, new_px: new_px, old_px: old_px});
    issued_count++;
  endfunction

  task automatic push_random(input int count);
    int         sel;
    int         slot;
    rgb_t       px;
    rgb_t       px_old;
    logic [PIX_W-1:0] idx;
    @(negedge clk);
    repeat (count) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        // frame sequence: the leaving pixel is the one sent a full window ago
        slot = ($urandom_range(99) < 40) ? last_slot : $urandom_range(HIST_SLOTS - 1);
        last_slot = slot;
        px = rgb_t'($urandom);
        px_old = (frame_history[slot].size() >= WINDOW_N) ?
                 frame_history[slot].pop_front() : '0;
        frame_history[slot].insert(frame_history[slot].size(), px);
        idx = (slot == HIST_SLOTS - 1) ? '1 : PIX_W'(slot);
        push_req(idx, px, px_old);
      end else if (sel < 90) begin
        push_req(PIX_W'($urandom), rgb_t'($urandom), rgb_t'($urandom));
      end else begin
        // broken sequence: keep adding bright pixels to force the sums to wrap
        push_req(PIX_W'(32'h40 + $urandom_range(3)), '1, rgb_t'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Grey mode with reset weights.
    @(negedge clk);
    push_req(20'h00000, 24'h000000, 24'h000000);
    push_req(20'hFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    repeat (4) push_req(20'hFFFFF, 24'hFFFFFF, 24'h000000);
    repeat (2) push_req(20'h00000, 24'h000000, 24'hFFFFFF);
    push_req(20'hAAAAA, 24'hAAAAAA, 24'h555555);
    push_req(20'h55555, 24'h555555, 24'hAAAAAA);
    push_req(20'hAAAAA, 24'h0000FF, 24'h00FF00);

    // Colour mode reuses the red sum left by grey mode.
    configure(1'b0, 8'd255, 8'd255, 8'd255, 4'd15, IDLE_SENDER_LIGHT);
    @(negedge clk);
    push_req(20'hFFFFF, 24'hFFFFFF, 24'h000000);
    push_req(20'hFFFFF, 24'h000000, 24'hFFFFFF);
    repeat (3) push_req(20'h00000, 24'hFFFFFF, 24'h000000);
    push_req(20'h55555, 24'h00FF00, 24'hFF0000);
    push_req(20'hAAAAA, 24'hFF0000, 24'h0000FF);
    push_random(200);
    hold_go = 1'b1;

    configure(1'b1, 8'd255, 8'd255, 8'd255, 4'd15, IDLE_SENDER_LIGHT);
    push_random(200);
    configure(1'b1, 8'd255, 8'd255, 8'd255, 4'd0, IDLE_SENDER_HEAVY);
    push_random(200);
    configure(1'b0, 8'd0, 8'd0, 8'd0, 4'd0, IDLE_SENDER_HEAVY);
    push_random(100);
    configure(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 4'($urandom_range(15)), IDLE_SENDER_HEAVY);
    push_random(200);
    configure(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 4'($urandom_range(15)), IDLE_NONE);
    push_random(200);
    configure(1'b1, 8'd77, 8'd150, 8'd29, 4'd8, IDLE_NONE);
    push_random(200);

    drain();
    if (diff_expect_q.size() != 0) begin
      $error("difference: %0d expected results never arrived", diff_expect_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("running_mean_background_subtract regression: pass");
    end else begin
      $display("running_mean_background_subtract regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
